>>> hw/rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg: postfix evaluator shared definitions
// Widths, token codes, status codes and control types used by the stack
// cells, the divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

	// sizes
	localparam int STACK_DEPTH = 16;
	localparam int VALUE_W     = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(VALUE_W);

	// token codes
	localparam logic [7:0] TOK_ADD  = 8'h2B;
	localparam logic [7:0] TOK_SUB  = 8'h2D;
	localparam logic [7:0] TOK_MUL  = 8'h2A;
	localparam logic [7:0] TOK_DIV  = 8'h2F;
	localparam logic [7:0] TOK_ZERO = 8'h30;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// per-cell move command
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_cmd_t;

	// sequencer states
	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_MUL,
		FSM_DIV,
		FSM_DONE
	} fsm_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/pee_cell.sv
// ----------------------------------------------------------------------------
// pee_cell: one stack entry
// Holds one value and on command takes the value of its upper neighbor
// (push) or its lower neighbor (pop).
// ----------------------------------------------------------------------------
`default_nettype none

module pee_cell (
	input  wire logic                      clk,
	input  wire pee_pkg::cell_cmd_t        cmd,
	input  wire logic [pee_pkg::VALUE_W-1:0] prev_data,
	input  wire logic [pee_pkg::VALUE_W-1:0] next_data,
	output logic      [pee_pkg::VALUE_W-1:0] data
);
	import pee_pkg::*;

	logic [VALUE_W-1:0] data_q;

	// entry register, no reset: undefined until written
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_PUSH: data_q <= prev_data;
			CELL_POP:  data_q <= next_data;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/pee_divider.sv
// ----------------------------------------------------------------------------
// pee_divider: signed iterative divider
// Restoring division on magnitudes, one quotient bit per cycle, sign of the
// quotient applied at the output. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pee_pkg::VALUE_W-1:0] dividend,
	input  wire logic [pee_pkg::VALUE_W-1:0] divisor,
	output pee_pkg::div_status_t             stat,
	output logic      [pee_pkg::VALUE_W-1:0] quotient
);
	import pee_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [VALUE_W-1:0]   rem_q;
	logic [VALUE_W-1:0]   quo_q;
	logic [VALUE_W-1:0]   dvs_q;

	logic [VALUE_W-1:0] mag_a;
	logic [VALUE_W-1:0] mag_b;
	logic [VALUE_W:0]   shifted;
	logic [VALUE_W:0]   diff;

	// operand magnitudes
	assign mag_a = dividend[VALUE_W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b = divisor[VALUE_W-1]  ? (~divisor + 1'b1)  : divisor;

	// one restoring step
	assign shifted = {rem_q, quo_q[VALUE_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(VALUE_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
		end else if (busy_q) begin
			if (!diff[VALUE_W]) begin
				rem_q <= diff[VALUE_W-1:0];
				quo_q <= {quo_q[VALUE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VALUE_W-1:0];
				quo_q <= {quo_q[VALUE_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix expression evaluation stack
// Evaluates a postfix expression fed as byte tokens and reports the value.
// ----------------------------------------------------------------------------
// Each item is one token. The bytes + - * / pop two values and push the
// 32-bit wrapped result (division truncates toward zero); any other byte
// pushes its value minus 48. On an item with last set the top value is
// returned with a status (0 ok, 1 underflow, 2 overflow, 3 divide by zero,
// value 0 on error) and the stack is emptied. The stack is a row of 16
// cells that shift toward or away from the top. A push, add, subtract or
// error token passes EXEC and DONE before the next acceptance, a multiply
// also MUL (product registered before write back), and a divide also DIV,
// waiting on the divider that produces one quotient bit per cycle.
// A last item also waits while an earlier result is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        token_valid,
	output logic             token_ready,
	input  wire logic [7:0]  token,
	input  wire logic        last,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic signed [31:0] value,
	output logic [1:0]       status
);
	import pee_pkg::*;

	fsm_t               state_q, state_d;
	logic [7:0]         token_q;
	logic               last_q;
	logic [SP_W-1:0]    sp_q, sp_d;
	status_t            err_q, err_d;
	logic [VALUE_W-1:0] prod_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t            out_status_q;

	cell_cmd_t          stack_cmd;
	logic [VALUE_W-1:0] wr_data;
	logic               mul_load;
	logic               div_start;
	logic               out_load;
	logic [VALUE_W-1:0] cell_data [STACK_DEPTH];
	logic [VALUE_W-1:0] tos;
	logic [VALUE_W-1:0] nos;
	logic [VALUE_W-1:0] push_val;
	logic               is_op;
	div_status_t        div_stat;
	logic [VALUE_W-1:0] quotient;

	assign tos      = cell_data[0];
	assign nos      = cell_data[1];
	assign push_val = {{(VALUE_W-8){1'b0}}, token_q} - VALUE_W'(TOK_ZERO);
	assign is_op    = (token_q == TOK_ADD) || (token_q == TOK_SUB) ||
	                  (token_q == TOK_MUL) || (token_q == TOK_DIV);

	// stack cells
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_cmd_t          cmd_i;
		logic [VALUE_W-1:0] prev_i;
		logic [VALUE_W-1:0] next_i;

		// the top cell loads the new value on both push and collapse
		assign cmd_i  = (i == 0 && stack_cmd == CELL_POP) ? CELL_PUSH : stack_cmd;
		assign prev_i = (i == 0) ? wr_data : cell_data[(i == 0) ? 0 : i-1];
		assign next_i = cell_data[(i == STACK_DEPTH-1) ? i : i+1];

		pee_cell u_cell (
			.clk       (clk),
			.cmd       (cmd_i),
			.prev_data (prev_i),
			.next_data (next_i),
			.data      (cell_data[i])
		);
	end

	// divider, used by divide tokens
	pee_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nos),
		.divisor  (tos),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		sp_d      = sp_q;
		err_d     = err_q;
		stack_cmd = CELL_HOLD;
		wr_data   = push_val;
		mul_load  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (token_valid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				state_d = FSM_DONE;
				if (err_q != ST_OK) begin
					state_d = FSM_DONE;
				end else if (!is_op) begin
					if (sp_q == SP_W'(STACK_DEPTH)) begin
						err_d = ST_OVER;
					end else begin
						stack_cmd = CELL_PUSH;
						sp_d      = sp_q + 1'b1;
					end
				end else if (sp_q < SP_W'(2)) begin
					err_d = ST_UNDER;
				end else begin
					case (token_q)
						TOK_ADD: begin
							wr_data   = nos + tos;
							stack_cmd = CELL_POP;
							sp_d      = sp_q - 1'b1;
						end
						TOK_SUB: begin
							wr_data   = nos - tos;
							stack_cmd = CELL_POP;
							sp_d      = sp_q - 1'b1;
						end
						TOK_MUL: begin
							mul_load = 1'b1;
							state_d  = FSM_MUL;
						end
						default: begin
							if (tos == '0) begin
								err_d     = ST_DIVZ;
								wr_data   = '0;
								stack_cmd = CELL_POP;
								sp_d      = sp_q - 1'b1;
							end else begin
								div_start = 1'b1;
								state_d   = FSM_DIV;
							end
						end
					endcase
				end
			end
			FSM_MUL: begin
				wr_data   = prod_q;
				stack_cmd = CELL_POP;
				sp_d      = sp_q - 1'b1;
				state_d   = FSM_DONE;
			end
			FSM_DIV: begin
				if (div_stat.done) begin
					wr_data   = quotient;
					stack_cmd = CELL_POP;
					sp_d      = sp_q - 1'b1;
					state_d   = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (!last_q) begin
					state_d = FSM_IDLE;
				end else if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					sp_d     = '0;
					err_d    = ST_OK;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			sp_q        <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture, product and result registers
	always_ff @(posedge clk) begin
		if (token_valid && token_ready) begin
			token_q <= token;
			last_q  <= last;
		end
		if (mul_load) begin
			prod_q <= VALUE_W'(nos * tos);
		end
		if (out_load) begin
			if (err_q != ST_OK) begin
				out_status_q <= err_q;
				out_value_q  <= '0;
			end else if (sp_q == '0) begin
				out_status_q <= ST_UNDER;
				out_value_q  <= '0;
			end else begin
				out_status_q <= ST_OK;
				out_value_q  <= tos;
			end
		end
	end

	assign token_ready  = (state_q == FSM_IDLE);
	assign result_valid = out_valid_q;
	assign value        = out_value_q;
	assign status       = out_status_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && state_q != FSM_DONE) |=> $stable(err_q))
		else $error("error code changed before end of expression");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |-> (value == '0))
		else $error("error result with nonzero value");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_IDLE) |-> !div_stat.busy)
		else $error("divider busy while taking an item");

endmodule

`default_nettype wire
